// ===== rtl/rqi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqi_pkg
// Types and constants shared by the remote input qualifier modules.
// ----------------------------------------------------------------------------
package rqi_pkg;

   localparam int CNT_W = 9;
   localparam int THR_W = 8;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_ARM   = 2'd1,
      OP_ACK   = 2'd2,
      OP_APPLY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_START_MODE    = 2'd0,
      REG_MARK_MODE     = 2'd1,
      REG_READY_LEVEL   = 2'd2,
      REG_TRIGGER_COUNT = 2'd3
   } reg_index_type;

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_RISE = 2'd1;

   localparam logic [THR_W-1:0] TRIGGER_RESET = 8'd5;
   localparam logic             PIN_MASK      = 1'b1;

   typedef struct packed {
      logic [1:0]       start_mode;
      logic [1:0]       mark_mode;
      logic             ready_level;
      logic [THR_W-1:0] trigger_count;
   } cfg_type;

   typedef struct packed {
      logic             enabled;
      logic             seen;
      logic [CNT_W-1:0] count;
      logic             flag;
   } chan_type;

   typedef struct packed {
      logic irq;
      logic start_detected;
      logic mark_detected;
      logic ready_state;
   } result_type;

endpackage

// ===== rtl/rqi_oneshot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqi_oneshot
// Tick update of one armed one-shot debounce channel.
// ----------------------------------------------------------------------------
module rqi_oneshot (
   input  logic                     go_i,
   input  logic                     pin_i,
   input  logic                     level_i,
   input  logic [rqi_pkg::THR_W-1:0] thr_i,
   input  rqi_pkg::chan_type        chan_i,
   output rqi_pkg::chan_type        chan_o,
   output logic                     fire_o
);

   logic [rqi_pkg::CNT_W-1:0] thr_ext;

   assign thr_ext = {1'b0, thr_i};

   always_comb begin
      chan_o = chan_i;
      fire_o = 1'b0;
      if (go_i) begin
         if ((pin_i & rqi_pkg::PIN_MASK) == level_i) begin
            if (chan_i.seen) begin
               chan_o.count = chan_i.count + 1'b1;
               if (chan_i.count > thr_ext) begin
                  chan_o.flag    = 1'b1;
                  chan_o.count   = thr_ext;
                  chan_o.seen    = 1'b0;
                  chan_o.enabled = 1'b0;
                  fire_o         = 1'b1;
               end
            end
         end else begin
            chan_o.flag  = 1'b0;
            chan_o.count = '0;
            chan_o.seen  = 1'b1;
         end
      end
   end

endmodule

// ===== rtl/rqi_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqi_core
// Channel state and per-word update for start, mark and ready.
// ----------------------------------------------------------------------------
module rqi_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_i,
   input  rqi_pkg::op_type     op_i,
   input  logic                start_pin_i,
   input  logic                mark_pin_i,
   input  logic                ready_pin_i,
   input  logic                arm_enable_i,
   input  rqi_pkg::cfg_type    cfg_i,
   output rqi_pkg::result_type res_o
);

   rqi_pkg::chan_type start_ff, start_in, start_tick;
   rqi_pkg::chan_type mark_ff, mark_in, mark_tick;
   logic              sw_armed_ff, sw_armed_in;
   logic              start_lvl_ff, start_lvl_in;
   logic              mark_lvl_ff, mark_lvl_in;
   logic              ready_lvl_ff, ready_lvl_in;
   logic [rqi_pkg::CNT_W-1:0] ract_ff, ract_in;
   logic [rqi_pkg::CNT_W-1:0] rinact_ff, rinact_in;
   logic              ready_ff, ready_in;
   logic              start_fire, mark_fire, start_go, mark_go, irq;
   logic [rqi_pkg::CNT_W-1:0] thr_ext;

   assign thr_ext  = {1'b0, cfg_i.trigger_count};
   assign start_go = (op_i == rqi_pkg::OP_TICK) && start_ff.enabled && sw_armed_ff;
   assign mark_go  = (op_i == rqi_pkg::OP_TICK) && mark_ff.enabled;

   rqi_oneshot u_start (
      .go_i    (start_go),
      .pin_i   (start_pin_i),
      .level_i (start_lvl_ff),
      .thr_i   (cfg_i.trigger_count),
      .chan_i  (start_ff),
      .chan_o  (start_tick),
      .fire_o  (start_fire)
   );

   rqi_oneshot u_mark (
      .go_i    (mark_go),
      .pin_i   (mark_pin_i),
      .level_i (mark_lvl_ff),
      .thr_i   (cfg_i.trigger_count),
      .chan_i  (mark_ff),
      .chan_o  (mark_tick),
      .fire_o  (mark_fire)
   );

   always_comb begin
      start_in     = start_ff;
      mark_in      = mark_ff;
      sw_armed_in  = sw_armed_ff;
      start_lvl_in = start_lvl_ff;
      mark_lvl_in  = mark_lvl_ff;
      ready_lvl_in = ready_lvl_ff;
      ract_in      = ract_ff;
      rinact_in    = rinact_ff;
      ready_in     = ready_ff;
      irq          = 1'b0;
      case (op_i)
         rqi_pkg::OP_TICK: begin
            start_in = start_tick;
            mark_in  = mark_tick;
            irq      = start_fire | mark_fire;
            if ((ready_pin_i & rqi_pkg::PIN_MASK) == ready_lvl_ff) begin
               ract_in = ract_ff + 1'b1;
               if (ract_ff > thr_ext) begin
                  if (!ready_ff) begin
                     irq       = 1'b1;
                     ready_in  = 1'b1;
                     rinact_in = '0;
                  end
                  ract_in = thr_ext;
               end
            end else begin
               rinact_in = rinact_ff + 1'b1;
               if (rinact_ff > thr_ext) begin
                  if (ready_ff) begin
                     irq      = 1'b1;
                     ready_in = 1'b0;
                     ract_in  = '0;
                  end
                  rinact_in = thr_ext;
               end
            end
         end
         rqi_pkg::OP_ARM: begin
            if (arm_enable_i) begin
               start_in.count = '0;
               start_in.seen  = 1'b0;
               sw_armed_in    = 1'b1;
            end else begin
               sw_armed_in = 1'b0;
            end
         end
         rqi_pkg::OP_ACK: begin
            start_in.flag   = 1'b0;
            mark_in.enabled = 1'b1;
         end
         rqi_pkg::OP_APPLY: begin
            start_in.enabled = (cfg_i.start_mode != rqi_pkg::MODE_OFF);
            if (cfg_i.start_mode != rqi_pkg::MODE_OFF) begin
               start_lvl_in = (cfg_i.start_mode == rqi_pkg::MODE_RISE);
            end
            mark_in.enabled = (cfg_i.mark_mode != rqi_pkg::MODE_OFF);
            if (cfg_i.mark_mode != rqi_pkg::MODE_OFF) begin
               mark_lvl_in = (cfg_i.mark_mode == rqi_pkg::MODE_RISE);
            end
            ready_lvl_in = cfg_i.ready_level;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res_o.irq            = irq;
      res_o.start_detected = start_in.flag;
      res_o.mark_detected  = mark_in.flag;
      res_o.ready_state    = ready_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         mark_ff      <= '0;
         sw_armed_ff  <= 1'b0;
         start_lvl_ff <= 1'b0;
         mark_lvl_ff  <= 1'b0;
         ready_lvl_ff <= 1'b0;
         ract_ff      <= '0;
         rinact_ff    <= '0;
         ready_ff     <= 1'b0;
      end else if (step_i) begin
         start_ff     <= start_in;
         mark_ff      <= mark_in;
         sw_armed_ff  <= sw_armed_in;
         start_lvl_ff <= start_lvl_in;
         mark_lvl_ff  <= mark_lvl_in;
         ready_lvl_ff <= ready_lvl_in;
         ract_ff      <= ract_in;
         rinact_ff    <= rinact_in;
         ready_ff     <= ready_in;
      end
   end

   a_start_rise_on_tick : assert property (@(posedge clock) disable iff (reset)
      $rose(start_ff.flag) |-> $past(step_i && op_i == rqi_pkg::OP_TICK))
      else $error("start flag set outside a tick");

   a_mark_fire_disables : assert property (@(posedge clock) disable iff (reset)
      $rose(mark_ff.flag) |-> !mark_ff.enabled)
      else $error("mark fired but channel still enabled");

   a_irq_only_tick : assert property (@(posedge clock) disable iff (reset)
      (step_i && op_i != rqi_pkg::OP_TICK) |-> !res_o.irq)
      else $error("interrupt on a non-tick word");

   a_ready_change_irq : assert property (@(posedge clock) disable iff (reset)
      (step_i && (ready_in != ready_ff)) |-> res_o.irq)
      else $error("ready change without interrupt");

endmodule

// ===== rtl/remote_input_qualifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_input_qualifier_top
// Debounced, armed detection of remote start, mark and ready contacts.
//
//   channel | handshake           | payload
//   req     | req_valid/req_stall | opcode, start/mark/ready pins, arm_enable
//   rsp     | rsp_valid/rsp_stall | interrupt, start/mark detected, ready state
//   csr     | csr_valid/csr_ready | csr_index, csr_data
//
// One word per cycle while rsp is not stalled; a word reaches rsp through the
// input register and then the result register around the channel update logic.
// A stalled rsp holds the result; the input register keeps accepting while the
// result register is free or drains in the same cycle.
// Reset clears all channel state; thresholds return to their reset values.
// ----------------------------------------------------------------------------
module remote_input_qualifier_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic       req_start_pin,
   input  logic       req_mark_pin,
   input  logic       req_ready_pin,
   input  logic       req_arm_enable,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_interrupt,
   output logic       rsp_start_detected,
   output logic       rsp_mark_detected,
   output logic       rsp_ready_state,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   rqi_pkg::cfg_type    cfg_ff;
   rqi_pkg::op_type     op_ff;
   logic                in_valid_ff, in_valid_in;
   logic                start_pin_ff, mark_pin_ff, ready_pin_ff, arm_ff;
   logic                out_valid_ff, out_valid_in;
   rqi_pkg::result_type res_ff, res;
   logic                out_free, step, accept;

   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept | (in_valid_ff & ~step);
   assign out_valid_in = step | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_mode    <= rqi_pkg::MODE_OFF;
         cfg_ff.mark_mode     <= rqi_pkg::MODE_OFF;
         cfg_ff.ready_level   <= 1'b0;
         cfg_ff.trigger_count <= rqi_pkg::TRIGGER_RESET;
      end else if (csr_valid && csr_ready) begin
         case (rqi_pkg::reg_index_type'(csr_index))
            rqi_pkg::REG_START_MODE:    cfg_ff.start_mode    <= csr_data[1:0];
            rqi_pkg::REG_MARK_MODE:     cfg_ff.mark_mode     <= csr_data[1:0];
            rqi_pkg::REG_READY_LEVEL:   cfg_ff.ready_level   <= csr_data[0];
            rqi_pkg::REG_TRIGGER_COUNT: cfg_ff.trigger_count <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= rqi_pkg::op_type'(req_opcode);
         start_pin_ff <= req_start_pin;
         mark_pin_ff  <= req_mark_pin;
         ready_pin_ff <= req_ready_pin;
         arm_ff       <= req_arm_enable;
      end
      if (step) begin
         res_ff <= res;
      end
   end

   rqi_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_i       (step),
      .op_i         (op_ff),
      .start_pin_i  (start_pin_ff),
      .mark_pin_i   (mark_pin_ff),
      .ready_pin_i  (ready_pin_ff),
      .arm_enable_i (arm_ff),
      .cfg_i        (cfg_ff),
      .res_o        (res)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_interrupt      = res_ff.irq;
   assign rsp_start_detected = res_ff.start_detected;
   assign rsp_mark_detected  = res_ff.mark_detected;
   assign rsp_ready_state    = res_ff.ready_state;

endmodule

// ===== dv/remote_input_qualifier_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_input_qualifier_top_tb
// Self-checking bench for the remote input qualifier. A clocked driver feeds
// request words from a queue, and a shadow of the qualifier predicts each
// result when its word is accepted. A clocked monitor checks every response
// field in order. Phases cover several register settings, including both
// threshold extremes, with random idling on both sides and a long response
// hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module remote_input_qualifier_top_tb;

   localparam int LIMIT       = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [1:0] MODE_FALL = 2'd2;
   localparam logic [1:0] MODE_ALT  = 2'd3;

   typedef struct packed {
      rqi_pkg::op_type op;
      logic            start_pin;
      logic            mark_pin;
      logic            ready_pin;
      logic            arm;
   } req_word_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [1:0] req_opcode     = '0;
   logic       req_start_pin  = 1'b0;
   logic       req_mark_pin   = 1'b0;
   logic       req_ready_pin  = 1'b0;
   logic       req_arm_enable = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_interrupt;
   logic       rsp_start_detected;
   logic       rsp_mark_detected;
   logic       rsp_ready_state;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index      = '0;
   logic [7:0] csr_data       = '0;

   remote_input_qualifier_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_start_pin      (req_start_pin),
      .req_mark_pin       (req_mark_pin),
      .req_ready_pin      (req_ready_pin),
      .req_arm_enable     (req_arm_enable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_interrupt      (rsp_interrupt),
      .rsp_start_detected (rsp_start_detected),
      .rsp_mark_detected  (rsp_mark_detected),
      .rsp_ready_state    (rsp_ready_state),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   rqi_pkg::cfg_type          cfg_shadow;
   rqi_pkg::chan_type         start_ch;
   rqi_pkg::chan_type         mark_ch;
   logic                      start_armed;
   logic                      start_lvl;
   logic                      mark_lvl;
   logic                      ready_lvl;
   logic [rqi_pkg::CNT_W-1:0] ready_act_cnt;
   logic [rqi_pkg::CNT_W-1:0] ready_inact_cnt;
   logic                      ready_q;

   req_word_type        pending[$];
   rqi_pkg::result_type expected_results[$];
   req_word_type        offered;

   int send_idle_pct      = 0;
   int stall_pct          = 0;
   int queued_count       = 0;
   int accepted_count     = 0;
   int checked_count      = 0;
   int error_count        = 0;
   int start_fires        = 0;
   int mark_fires         = 0;
   int ready_changes      = 0;
   int input_stall_cycles = 0;
   int cycle_count        = 0;
   int hold_left          = 0;
   logic hold_start       = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rqi_pkg::chan_type chan_tick(rqi_pkg::chan_type ch, logic pin,
                                                   logic lvl,
                                                   logic [rqi_pkg::THR_W-1:0] thr,
                                                   output logic fired);
      logic [rqi_pkg::CNT_W-1:0] prev;
      fired = 1'b0;
      prev  = ch.count;
      if (pin == lvl) begin
         if (ch.seen) begin
            ch.count = prev + 1'b1;
            if (prev > {1'b0, thr}) begin
               ch.flag    = 1'b1;
               ch.count   = {1'b0, thr};
               ch.seen    = 1'b0;
               ch.enabled = 1'b0;
               fired      = 1'b1;
            end
         end
      end else begin
         ch.flag  = 1'b0;
         ch.count = '0;
         ch.seen  = 1'b1;
      end
      return ch;
   endfunction

   function automatic rqi_pkg::result_type predict_result(req_word_type w);
      rqi_pkg::result_type       r;
      logic                      fired;
      logic [rqi_pkg::CNT_W-1:0] prev;
      logic [rqi_pkg::CNT_W-1:0] thr_ext;
      logic [rqi_pkg::THR_W-1:0] thr;
      r       = '0;
      thr     = cfg_shadow.trigger_count;
      thr_ext = {1'b0, thr};
      case (w.op)
         rqi_pkg::OP_TICK: begin
            if (start_ch.enabled && start_armed) begin
               start_ch = chan_tick(start_ch, w.start_pin, start_lvl, thr, fired);
               if (fired) begin
                  r.irq = 1'b1;
                  start_fires++;
               end
            end
            if (mark_ch.enabled) begin
               mark_ch = chan_tick(mark_ch, w.mark_pin, mark_lvl, thr, fired);
               if (fired) begin
                  r.irq = 1'b1;
                  mark_fires++;
               end
            end
            if (w.ready_pin == ready_lvl) begin
               prev          = ready_act_cnt;
               ready_act_cnt = prev + 1'b1;
               if (prev > thr_ext) begin
                  if (!ready_q) begin
                     r.irq           = 1'b1;
                     ready_q         = 1'b1;
                     ready_inact_cnt = '0;
                     ready_changes++;
                  end
                  ready_act_cnt = thr_ext;
               end
            end else begin
               prev            = ready_inact_cnt;
               ready_inact_cnt = prev + 1'b1;
               if (prev > thr_ext) begin
                  if (ready_q) begin
                     r.irq         = 1'b1;
                     ready_q       = 1'b0;
                     ready_act_cnt = '0;
                     ready_changes++;
                  end
                  ready_inact_cnt = thr_ext;
               end
            end
         end
         rqi_pkg::OP_ARM: begin
            if (w.arm) begin
               start_ch.count = '0;
               start_ch.seen  = 1'b0;
               start_armed    = 1'b1;
            end else begin
               start_armed = 1'b0;
            end
         end
         rqi_pkg::OP_ACK: begin
            start_ch.flag   = 1'b0;
            mark_ch.enabled = 1'b1;
         end
         default: begin
            start_ch.enabled = (cfg_shadow.start_mode != rqi_pkg::MODE_OFF);
            if (start_ch.enabled) start_lvl = (cfg_shadow.start_mode == rqi_pkg::MODE_RISE);
            mark_ch.enabled = (cfg_shadow.mark_mode != rqi_pkg::MODE_OFF);
            if (mark_ch.enabled) mark_lvl = (cfg_shadow.mark_mode == rqi_pkg::MODE_RISE);
            ready_lvl = cfg_shadow.ready_level;
         end
      endcase
      r.start_detected = start_ch.flag;
      r.mark_detected  = mark_ch.flag;
      r.ready_state    = ready_q;
      return r;
   endfunction

   task automatic check_field(string name, logic want, logic got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
         error_count++;
      end
   endtask

   // driver: predict on acceptance, then offer the next word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_result(offered));
            accepted_count++;
         end
         if (req_valid && req_stall) input_stall_cycles++;
         if (!req_valid || !req_stall) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending.pop_front();
               req_valid      <= 1'b1;
               req_opcode     <= offered.op;
               req_start_pin  <= offered.start_pin;
               req_mark_pin   <= offered.mark_pin;
               req_ready_pin  <= offered.ready_pin;
               req_arm_enable <= offered.arm;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rqi_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %b", $time,
                        {rsp_interrupt, rsp_start_detected, rsp_mark_detected,
                         rsp_ready_state});
               error_count++;
            end else begin
               want = expected_results.pop_front();
               checked_count++;
               check_field("interrupt", want.irq, rsp_interrupt);
               check_field("start_detected", want.start_detected, rsp_start_detected);
               check_field("mark_detected", want.mark_detected, rsp_mark_detected);
               check_field("ready_state", want.ready_state, rsp_ready_state);
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
      end
   end

   // long response hold-off
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_word(rqi_pkg::op_type op, logic sp, logic mp, logic rp, logic arm);
      req_word_type w;
      w.op        = op;
      w.start_pin = sp;
      w.mark_pin  = mp;
      w.ready_pin = rp;
      w.arm       = arm;
      pending.push_back(w);
      queued_count++;
   endtask

   task automatic csr_write(rqi_pkg::reg_index_type idx, logic [7:0] value);
      logic [7:0] junk;
      logic [7:0] data;
      junk = 8'($urandom);
      case (idx)
         rqi_pkg::REG_START_MODE, rqi_pkg::REG_MARK_MODE: data = {junk[7:2], value[1:0]};
         rqi_pkg::REG_READY_LEVEL: data = {junk[7:1], value[0]};
         default: data = value;
      endcase
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         rqi_pkg::REG_START_MODE: cfg_shadow.start_mode = data[1:0];
         rqi_pkg::REG_MARK_MODE: cfg_shadow.mark_mode = data[1:0];
         rqi_pkg::REG_READY_LEVEL: cfg_shadow.ready_level = data[0];
         default: cfg_shadow.trigger_count = data;
      endcase
   endtask

   task automatic set_config(logic [1:0] sm, logic [1:0] mm, logic rl, logic [7:0] thr);
      csr_write(rqi_pkg::REG_START_MODE, {6'd0, sm});
      csr_write(rqi_pkg::REG_MARK_MODE, {6'd0, mm});
      csr_write(rqi_pkg::REG_READY_LEVEL, {7'd0, rl});
      csr_write(rqi_pkg::REG_TRIGGER_COUNT, thr);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // apply and arm, then pin runs of random length with sparse commands and noise
   task automatic run_random(int n, int max_run, int other_pct);
      logic [2:0] lvl;
      logic [2:0] noise;
      int         run_left[3];
      int         pick;
      lvl = 3'($urandom);
      run_left = '{0, 0, 0};
      push_word(rqi_pkg::OP_APPLY, 1'b0, 1'b0, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_ARM, 1'b0, 1'b0, 1'b0, 1'b1);
      for (int i = 0; i < n; i++) begin
         noise = 3'($urandom);
         if ($urandom_range(99) < other_pct) begin
            pick = $urandom_range(5);
            if (pick < 3) begin
               push_word(rqi_pkg::OP_ARM, noise[0], noise[1], noise[2],
                         $urandom_range(3) != 0);
            end else if (pick < 5) begin
               push_word(rqi_pkg::OP_ACK, noise[0], noise[1], noise[2], 1'($urandom));
            end else begin
               push_word(rqi_pkg::OP_APPLY, noise[0], noise[1], noise[2], 1'($urandom));
            end
         end else begin
            for (int k = 0; k < 3; k++) begin
               if (run_left[k] == 0) begin
                  lvl[k]      = ~lvl[k];
                  run_left[k] = $urandom_range(max_run, 1);
               end
               run_left[k]--;
            end
            if ($urandom_range(199) < other_pct) begin
               push_word(rqi_pkg::OP_TICK, noise[0], noise[1], noise[2], 1'($urandom));
            end else begin
               push_word(rqi_pkg::OP_TICK, lvl[0], lvl[1], lvl[2], 1'($urandom));
            end
         end
      end
   endtask

   initial begin
      cfg_shadow.start_mode    = rqi_pkg::MODE_OFF;
      cfg_shadow.mark_mode     = rqi_pkg::MODE_OFF;
      cfg_shadow.ready_level   = 1'b0;
      cfg_shadow.trigger_count = rqi_pkg::TRIGGER_RESET;
      start_ch        = '0;
      mark_ch         = '0;
      start_armed     = 1'b0;
      start_lvl       = 1'b0;
      mark_lvl        = 1'b0;
      ready_lvl       = 1'b0;
      ready_act_cnt   = '0;
      ready_inact_cnt = '0;
      ready_q         = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, channels still disabled
      push_word(rqi_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1);
      push_word(rqi_pkg::OP_ACK, 1'b0, 1'b0, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_APPLY, 1'b0, 1'b0, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_ARM, 1'b1, 1'b1, 1'b1, 1'b0);
      drain();

      // zero threshold: fire on the second active tick
      set_config(rqi_pkg::MODE_RISE, MODE_FALL, 1'b1, 8'd0);
      push_word(rqi_pkg::OP_APPLY, 1'b0, 1'b0, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_ARM, 1'b0, 1'b0, 1'b0, 1'b1);
      push_word(rqi_pkg::OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0);
      push_word(rqi_pkg::OP_TICK, 1'b1, 1'b0, 1'b1, 1'b1);
      push_word(rqi_pkg::OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0);
      push_word(rqi_pkg::OP_ACK, 1'b0, 1'b0, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);
      push_word(rqi_pkg::OP_ARM, 1'b0, 1'b0, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_APPLY, 1'b0, 1'b0, 1'b0, 1'b0);
      push_word(rqi_pkg::OP_TICK, 1'b0, 1'b1, 1'b1, 1'b0);
      push_word(rqi_pkg::OP_TICK, 1'b1, 1'b1, 1'b1, 1'b0);
      drain();

      // both disabled, then ack re-enables mark on its old level
      set_config(rqi_pkg::MODE_OFF, rqi_pkg::MODE_OFF, 1'b0, 8'd255);
      push_word(rqi_pkg::OP_APPLY, 1'b1, 1'b1, 1'b1, 1'b1);
      push_word(rqi_pkg::OP_ACK, 1'b1, 1'b1, 1'b1, 1'b1);
      push_word(rqi_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 1'b1);
      push_word(rqi_pkg::OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0);
      drain();

      set_config(rqi_pkg::MODE_RISE, rqi_pkg::MODE_RISE, 1'b1, 8'd3);
      run_random(300, 8, 12);
      drain();

      set_config(MODE_FALL, MODE_FALL, 1'b0, 8'd0);
      send_idle_pct = 83;
      run_random(250, 4, 12);
      drain();

      set_config(MODE_ALT, rqi_pkg::MODE_OFF, 1'b0, 8'd7);
      send_idle_pct = 0;
      stall_pct     = 83;
      run_random(250, 10, 12);
      drain();

      set_config(rqi_pkg::MODE_RISE, MODE_FALL, 1'b1, 8'd2);
      send_idle_pct = 8;
      stall_pct     = 8;
      run_random(250, 6, 12);
      drain();

      // hold the response side while words keep coming
      send_idle_pct = 0;
      stall_pct     = 0;
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      run_random(60, 6, 12);
      drain();

      set_config(rqi_pkg::MODE_RISE, rqi_pkg::MODE_RISE, 1'b0, 8'd255);
      run_random(250, 300, 1);
      drain();

      $display("Checked %0d of %0d words over seven settings: %0d start, %0d mark fires,",
               checked_count, accepted_count, start_fires, mark_fires);
      $display("%0d ready changes; input backed up for %0d cycles",
               ready_changes, input_stall_cycles);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
